// ===== rtl/core/address_range_allocator_macros.svh =====
// Assertion helpers for the address range allocator.
`ifndef ADDRESS_RANGE_ALLOCATOR_MACROS_SVH
`define ADDRESS_RANGE_ALLOCATOR_MACROS_SVH

// Check a property on the rising clock edge, outside reset.
`define ARA_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on the rising clock edge, reset included.
`define ARA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/ara_pkg.sv =====
package ara_pkg;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [31:0] RESET_WINDOW_START = 32'h0010_0000;
    localparam logic [31:0] RESET_WINDOW_END   = 32'hffff_ffff;
    localparam logic [32:0] MASK32             = 33'h0_ffff_ffff;

    localparam int unsigned CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_START = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WINDOW_END   = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] region_start;
        logic [31:0] freed_bytes;
    } t_result;

endpackage

// ===== rtl/core/ara_table.sv =====
// Region table memory: one write port, one registered read port.
module ara_table
    import ara_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [64:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [64:0]   o_rdata
);

    logic [64:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/ara_seq.sv =====
// Sequencer: walks the region table one entry per step for search, insert
// shift and delete shift, using 33-bit adders and comparators.
module ara_seq
    import ara_pkg::*;
#(
    parameter int unsigned MAX_AREAS = 64,
    parameter int unsigned PAGE_BITS = 12,
    parameter int unsigned AW        = 6,
    parameter int unsigned CW        = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_opcode,
    input  logic [31:0]   i_request_bytes,
    input  logic [31:0]   i_free_start,
    input  logic [31:0]   i_window_start,
    input  logic [31:0]   i_window_end,
    output logic          o_done,
    output t_result       o_result,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [64:0]   o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [64:0]   i_rdata
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRD    = 4'd1;  // issue scan read
    localparam logic [3:0] S_SCAN   = 4'd2;  // first region with end >= addr
    localparam logic [3:0] S_WRD    = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;  // first-fit walk
    localparam logic [3:0] S_PRD    = 4'd5;
    localparam logic [3:0] S_POS    = 4'd6;  // insertion point
    localparam logic [3:0] S_IRD    = 4'd7;
    localparam logic [3:0] S_ISH    = 4'd8;  // shift up
    localparam logic [3:0] S_FRD    = 4'd9;
    localparam logic [3:0] S_FIND   = 4'd10; // match start
    localparam logic [3:0] S_CRD    = 4'd11;
    localparam logic [3:0] S_CACHE  = 4'd12;
    localparam logic [3:0] S_DRD    = 4'd13;
    localparam logic [3:0] S_DSH    = 4'd14; // shift down
    localparam logic [3:0] S_CRD2   = 4'd15; // cached entry read for alloc

    localparam logic [32:0] PMASK = 33'((64'd1 << PAGE_BITS) - 64'd1);

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_cvalid, n_cvalid;
    logic [AW-1:0] r_cidx, n_cidx;
    logic [32:0]   r_hole, n_hole;
    logic [CW-1:0] r_i, n_i;
    logic [32:0]   r_addr, n_addr;
    logic [32:0]   r_size, n_size;
    logic [32:0]   r_fstart, n_fstart;
    logic [32:0]   r_fend, n_fend;
    logic [AW-1:0] r_fidx, n_fidx;
    logic          r_done, n_done;
    t_result       r_res, n_res;

    logic [32:0] rd_start, rd_end, sum, end_up, size_rnd;
    logic [CW-1:0] i_next;

    assign rd_start = {1'b0, i_rdata[31:0]};
    assign rd_end   = i_rdata[64:32];
    assign sum      = r_addr + r_size;
    assign end_up   = (rd_end + PMASK) & ~PMASK;
    assign size_rnd = (((33'(i_request_bytes)) + PMASK) & ~PMASK) & MASK32;
    assign i_next   = r_i + CW'(1);

    assign o_done   = r_done;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cvalid <= 1'b0;
            r_cidx   <= '0;
            r_hole   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cvalid <= n_cvalid;
            r_cidx   <= n_cidx;
            r_hole   <= n_hole;
            r_done   <= n_done;
        end
        r_i      <= n_i;
        r_addr   <= n_addr;
        r_size   <= n_size;
        r_fstart <= n_fstart;
        r_fend   <= n_fend;
        r_fidx   <= n_fidx;
        r_res    <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cvalid = r_cvalid;
        n_cidx   = r_cidx;
        n_hole   = r_hole;
        n_i      = r_i;
        n_addr   = r_addr;
        n_size   = r_size;
        n_fstart = r_fstart;
        n_fend   = r_fend;
        n_fidx   = r_fidx;
        n_done   = 1'b0;
        n_res    = r_res;
        o_we     = 1'b0;
        o_waddr  = r_i[AW-1:0];
        o_wdata  = i_rdata;
        o_raddr  = r_i[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res = '{status: ST_OK, region_start: '0, freed_bytes: '0};
                    n_i   = '0;
                    if (i_opcode == OP_FREE) begin
                        n_fstart = {1'b0, i_free_start};
                        n_state  = S_FRD;
                    end else begin
                        n_size = size_rnd;
                        if (size_rnd == '0) begin
                            n_res.status = ST_NO_SPACE;
                            n_done = 1'b1;
                        end else if (r_count >= CW'(MAX_AREAS)) begin
                            n_res.status = ST_FULL;
                            n_done = 1'b1;
                        end else begin
                            // drop cache when invalid, on stale index or a request smaller than the hole
                            if ((r_cvalid && CW'(r_cidx) >= r_count) || !r_cvalid ||
                                size_rnd < r_hole) begin
                                n_hole   = '0;
                                n_cvalid = 1'b0;
                                n_addr   = {1'b0, i_window_start};
                                if (({1'b0, i_window_start} + size_rnd) > MASK32) begin
                                    n_res.status = ST_NO_SPACE;
                                    n_done = 1'b1;
                                end else if (r_count == '0) begin
                                    n_state = S_PRD;
                                end else begin
                                    n_state = S_SRD;
                                end
                            end else begin
                                n_i     = CW'(r_cidx);
                                n_state = S_CRD2;
                            end
                        end
                    end
                end
            end
            S_CRD2: begin
                n_state = S_CACHE;
            end
            S_CACHE: begin
                // cached restart point after the cached region
                n_addr = end_up;
                if (end_up < {1'b0, i_window_start} || end_up + r_size > MASK32) begin
                    n_res.status = ST_NO_SPACE;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_SRD: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (rd_end >= r_addr) begin
                    n_state = S_WALK;
                end else if (i_next >= r_count) begin
                    n_i     = '0;
                    n_state = S_PRD;
                end else begin
                    n_i     = i_next;
                    n_state = S_SRD;
                end
            end
            S_WRD: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (sum > rd_start && sum <= {1'b0, i_window_end}) begin
                    if (r_addr + r_hole < rd_start) begin
                        n_hole = rd_start - r_addr;
                    end
                    n_addr = end_up;
                    if (end_up + r_size > MASK32) begin
                        n_res.status = ST_NO_SPACE;
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end else if (i_next >= r_count) begin
                        n_i     = '0;
                        n_state = S_PRD;
                    end else begin
                        n_i     = i_next;
                        n_state = S_WRD;
                    end
                end else begin
                    n_i     = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                if (sum > {1'b0, i_window_end}) begin
                    n_res.status = ST_NO_SPACE;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (r_i >= r_count) begin
                    n_fidx  = r_i[AW-1:0];
                    n_i     = r_count;
                    n_state = (r_count == '0) ? S_ISH : S_IRD;
                end else begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                if (rd_start < r_addr) begin
                    n_i     = i_next;
                    n_state = S_PRD;
                end else begin
                    n_fidx  = r_i[AW-1:0];
                    n_i     = r_count;
                    n_state = S_IRD;
                end
            end
            S_IRD: begin
                // read entry i-1 for move to i
                o_raddr = AW'(r_i - CW'(1));
                n_state = S_ISH;
            end
            S_ISH: begin
                o_we    = 1'b1;
                o_waddr = r_i[AW-1:0];
                if (CW'(r_fidx) == r_i) begin
                    o_wdata = {r_addr + r_size, r_addr[31:0]};
                    n_count  = r_count + CW'(1);
                    n_cidx   = r_fidx;
                    n_cvalid = 1'b1;
                    n_res.region_start = r_addr[31:0];
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i - CW'(1);
                    n_state = (CW'(r_fidx) == r_i - CW'(1)) ? S_ISH : S_IRD;
                end
            end
            S_FRD: begin
                if (r_i >= r_count) begin
                    n_res.status = ST_NOT_FOUND;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (rd_start == r_fstart) begin
                    n_fend = rd_end;
                    n_fidx = r_i[AW-1:0];
                    n_res.freed_bytes = 32'(rd_end - rd_start);
                    o_raddr = r_cidx;
                    n_state = S_CRD;
                end else begin
                    n_i     = i_next;
                    n_state = S_FRD;
                end
            end
            S_CRD: begin
                // rdata now holds the cached entry
                if (r_cvalid && CW'(r_cidx) >= r_count) begin
                    n_cvalid = 1'b0;
                end else if (r_cvalid) begin
                    if (r_fend < {1'b0, i_window_start}) begin
                        n_cvalid = 1'b0;
                    end else if (r_fstart <= rd_start) begin
                        if (r_fidx == '0) n_cvalid = 1'b0;
                        else n_cidx = r_fidx - AW'(1);
                    end
                end
                n_i     = CW'(r_fidx);
                n_state = S_DRD;
            end
            S_DRD: begin
                if (i_next >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_raddr = AW'(i_next);
                    n_state = S_DSH;
                end
            end
            S_DSH: begin
                o_we    = 1'b1;
                o_waddr = r_i[AW-1:0];
                n_i     = i_next;
                n_state = S_DRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/address_range_allocator.sv =====
// Address range allocator.
// Hands out ranges rounded up to whole pages inside [window_start, window_end] and frees
// them by exact start address; up to MAX_AREAS regions are held in a table
// sorted by start address.
// Channels: s_axis carries one request item (opcode in tuser, size and free
// address in tdata); m_axis returns one result item per request (status,
// start, freed size). The config channel writes window_start (index 0) or
// window_end (index 1) and is always ready; write it only while idle.
// The table is walked through a single registered-read memory port. An early
// failure is answered without walking the table; an allocate does a scan and
// first-fit walk, then a slot search and shift up, and a free does a lookup,
// then a shift down.
// Only one item is in flight; s_axis_tready is low while it works and while
// its result is held, so a new item is taken only once the result has gone.
// Reset clears the region count and the search cache and loads the reset windows;
// the table itself needs no clearing pass. A stalled receiver holds the result in the
// output register and no new item is accepted until it is taken.
module address_range_allocator
    import ara_pkg::*;
#(
    parameter int unsigned MAX_AREAS = 64,
    parameter int unsigned PAGE_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // request_bytes[31:0], free_start[63:32]
    input  logic [0:0]  s_axis_tuser,  // opcode[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // status[1:0], region_start[33:2], freed_bytes[65:34]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned AW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int unsigned CW = $clog2(MAX_AREAS + 1);

    logic [31:0] r_wstart, r_wend;
    logic        r_busy;
    logic        r_ovalid;
    t_result     r_out;
    logic        start, done;
    t_result     res;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [64:0] wdata, rdata;

    assign o_cfg_ready   = 1'b1;
    // accept a new item only when idle and no result is held back
    assign s_axis_tready = !r_busy && !r_ovalid;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_out.freed_bytes, r_out.region_start, r_out.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart <= RESET_WINDOW_START;
            r_wend   <= RESET_WINDOW_END;
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_WINDOW_START) r_wstart <= i_cfg_data;
                if (i_cfg_index == CFG_WINDOW_END)   r_wend   <= i_cfg_data;
            end
            if (start) r_busy <= 1'b1;
            else if (done) r_busy <= 1'b0;
            // hold the result until taken
            if (done) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
        if (done) r_out <= res;
    end

    ara_seq #(.MAX_AREAS(MAX_AREAS), .PAGE_BITS(PAGE_BITS), .AW(AW), .CW(CW)) u_seq (
        .i_clk, .i_rst_n, .i_start(start),
        .i_opcode(s_axis_tuser[0]),
        .i_request_bytes(s_axis_tdata[31:0]),
        .i_free_start(s_axis_tdata[63:32]),
        .i_window_start(r_wstart), .i_window_end(r_wend),
        .o_done(done), .o_result(res),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_raddr(raddr), .i_rdata(rdata)
    );

    ara_table #(.DEPTH(MAX_AREAS), .AW(AW)) u_table (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

endmodule

// ===== rtl/core/ara_checker.sv =====
`include "address_range_allocator_macros.svh"
module ara_checker
    import ara_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata
);
    `ARA_ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
    `ARA_ASSERT_CLK(a_no_accept_out, m_axis_tvalid |-> !s_axis_tready, "accept with result held")
    `ARA_ASSERT_CLK(a_one_cycle, s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid, "result too early")
    `ARA_ASSERT_CLK(a_fail_zero, m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[33:2] == '0, "start on failure")
endmodule

bind address_range_allocator ara_checker u_ara_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
